### hdl/rmf_pkg.sv
package rmf_pkg;

  // Window length and the derived widths and indexes.
  localparam int WindowLen = 11;
  localparam int SampleW   = 8;
  localparam int AgeW      = $clog2(WindowLen);
  localparam int MedianIdx = WindowLen / 2;

  // Age of the oldest entry of a full window.
  localparam logic [AgeW-1:0] AgeMax = AgeW'(WindowLen - 1);

  // Contents of one cell of the sorted chain.
  typedef struct packed {
    logic               valid;
    logic [SampleW-1:0] value;
    logic [AgeW-1:0]    age;
  } cell_state_t;

  // Data that a cell hands to its right-hand neighbor in the same cycle.
  // dp: the entry being dropped sits at this cell or below it.
  // s:  the entry this cell holds once the dropped entry is squeezed out.
  // gt: s ranks above the new sample (an empty cell ranks above all).
  typedef struct packed {
    logic        dp;
    logic        gt;
    cell_state_t s;
  } cell_link_t;

endpackage

### hdl/rmf_sample_if.sv
interface rmf_sample_if;
  import rmf_pkg::*;

  logic               valid;
  logic               ready;
  logic [SampleW-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink (input valid, input sample, output ready);
endinterface

### hdl/rmf_median_if.sv
interface rmf_median_if;
  import rmf_pkg::*;

  logic               valid;
  logic               ready;
  logic [SampleW-1:0] median;

  modport source (output valid, output median, input ready);
  modport sink (input valid, input median, output ready);
endinterface

### hdl/rmf_cell.sv
module rmf_cell (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              shift_en_i,
  input  logic [rmf_pkg::SampleW-1:0]       sample_i,
  input  rmf_pkg::cell_link_t               left_link_i,
  input  rmf_pkg::cell_state_t              right_state_i,
  output rmf_pkg::cell_state_t              state_o,
  output rmf_pkg::cell_state_t              state_next_o,
  output rmf_pkg::cell_link_t               link_o
);
  import rmf_pkg::*;

  logic        valid_q, valid_d;
  logic [SampleW-1:0] value_q, value_d;
  logic [AgeW-1:0]    age_q, age_d;
  cell_state_t own;
  cell_state_t squeezed;
  logic        drop_here;
  logic        drop_at_or_below;
  logic        squeezed_gt;

  assign own = '{valid: valid_q, value: value_q, age: age_q};

  // The oldest entry of a full window leaves on every new sample.
  assign drop_here        = valid_q && (age_q == AgeMax);
  assign drop_at_or_below = left_link_i.dp | drop_here;
  assign squeezed         = drop_at_or_below ? right_state_i : own;
  assign squeezed_gt      = !squeezed.valid || (squeezed.value > sample_i);

  assign link_o = '{dp: drop_at_or_below, gt: squeezed_gt, s: squeezed};

  // Keep the squeezed entry if it ranks at or below the new sample, take the
  // new sample if this is its slot, or else take the left neighbor's entry.
  always_comb begin
    if (!squeezed_gt) begin
      valid_d = squeezed.valid;
      value_d = squeezed.value;
      age_d   = squeezed.valid ? squeezed.age + AgeW'(1) : '0;
    end else if (!left_link_i.gt) begin
      valid_d = 1'b1;
      value_d = sample_i;
      age_d   = '0;
    end else begin
      valid_d = left_link_i.s.valid;
      value_d = left_link_i.s.value;
      age_d   = left_link_i.s.valid ? left_link_i.s.age + AgeW'(1) : '0;
    end
  end

  assign state_o      = own;
  assign state_next_o = '{valid: valid_d, value: value_d, age: age_d};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (shift_en_i) begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (shift_en_i) begin
      value_q <= value_d;
      age_q   <= age_d;
    end
  end

endmodule

### hdl/running_median_filter.sv
// Running median filter over the newest WindowLen (default 11) unsigned 8-bit
// samples. Each sample transfer on in_i enters the window; once the window is
// full, every sample gives one transfer on out_o carrying the median (rank
// WindowLen/2 of the ascending window, the upper middle for an even length),
// with the sample just taken included. The first WindowLen-1 samples after
// reset give no result. The window is a chain of WindowLen cells kept in
// ascending order, each holding one sample and its age; on every sample the
// oldest entry drops out and the new one slots in, each cell deciding from
// its own contents and what its neighbors hand it. The result appears in the
// output register on the cycle after its transfer, and a new sample is taken
// every cycle while the output is free or being drained, so the sustained rate
// is one sample per clock. The limit on clock speed is the one-bit drop marker
// that ripples through the chain.
module running_median_filter (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  rmf_sample_if.sink           in_i,
  rmf_median_if.source         out_o
);
  import rmf_pkg::*;

  cell_state_t                 cell_state [WindowLen];
  cell_state_t                 cell_next  [WindowLen];
  cell_state_t                 right_state [WindowLen];
  cell_link_t                  cell_link  [WindowLen];
  cell_link_t                  left_link  [WindowLen];
  logic                        accept;
  logic                        out_vld_q, out_vld_d;
  logic [SampleW-1:0]          median_q;

  // A new sample is taken whenever the output register is empty or its
  // result is being taken in this same cycle.
  assign in_i.ready = !out_vld_q || out_o.ready;
  assign accept     = in_i.valid && in_i.ready;

  // The chain boundaries: nothing is dropped or ranked below the first cell,
  // and an empty cell lies beyond the last one.
  assign left_link[0]              = '{dp: 1'b0, gt: 1'b0, s: '0};
  assign right_state[WindowLen-1]  = '{valid: 1'b0, value: '0, age: '0};

  for (genvar i = 0; i < WindowLen; i++) begin : g_cell
    if (i > 0) begin : g_left
      assign left_link[i] = cell_link[i-1];
    end
    if (i < WindowLen - 1) begin : g_right
      assign right_state[i] = cell_state[i+1];
    end

    rmf_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .shift_en_i   (accept),
      .sample_i     (in_i.sample),
      .left_link_i  (left_link[i]),
      .right_state_i(right_state[i]),
      .state_o      (cell_state[i]),
      .state_next_o (cell_next[i]),
      .link_o       (cell_link[i])
    );
  end

  // The window is full once the top cell holds a sample; the median then
  // sits in the middle cell of the updated chain.
  always_comb begin
    if (accept) begin
      out_vld_d = cell_next[WindowLen-1].valid;
    end else if (out_o.ready) begin
      out_vld_d = 1'b0;
    end else begin
      out_vld_d = out_vld_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      median_q <= cell_next[MedianIdx].value;
    end
  end

  assign out_o.valid  = out_vld_q;
  assign out_o.median = median_q;

`ifndef SYNTH
  logic [WindowLen-1:0] age_zero;
  logic [WindowLen-2:0] order_ok;
  logic [WindowLen-2:0] packed_ok;

  for (genvar j = 0; j < WindowLen; j++) begin : g_chk_age
    assign age_zero[j] = cell_state[j].valid && (cell_state[j].age == '0);
  end
  for (genvar j = 0; j < WindowLen - 1; j++) begin : g_chk_pair
    assign order_ok[j]  = !cell_state[j+1].valid ||
                          (cell_state[j].value <= cell_state[j+1].value);
    assign packed_ok[j] = !cell_state[j+1].valid || cell_state[j].valid;
  end

  // Occupied cells stay in ascending order.
  a_sorted: assert property (@(posedge clk_i) disable iff (!rst_ni) &order_ok)
    else $error("median chain out of order");

  // Occupied cells form one block starting at the bottom of the chain.
  a_packed: assert property (@(posedge clk_i) disable iff (!rst_ni) &packed_ok)
    else $error("gap among occupied cells");

  // After a sample, exactly one occupied cell holds the newest entry.
  a_newest: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> $countones(age_zero) == 1)
    else $error("newest sample not unique in chain");

  // A result is only offered from a full window.
  a_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> cell_state[WindowLen-1].valid)
    else $error("result offered before window filled");
`endif

endmodule
